### sv/fqp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the FASTQ sequence/quality pair parser.
// No dependencies; fqp_ctrl and the top level import this package.
package fqp_pkg;

    localparam logic [7:0] CH_AT   = 8'd64;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_N    = 8'd78;

    // Parser phases
    localparam logic [2:0] PH_SEEK      = 3'd0;
    localparam logic [2:0] PH_SKIP_HDR  = 3'd1;
    localparam logic [2:0] PH_SEQ       = 3'd2;
    localparam logic [2:0] PH_SKIP_PLUS = 3'd3;
    localparam logic [2:0] PH_QUAL      = 3'd4;
    localparam logic [2:0] PH_ERROR     = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_SEP   = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_EXPECT_AT = 3'd1;
    localparam logic [2:0] ERR_TRUNC     = 3'd2;
    localparam logic [2:0] ERR_SHORT_QUAL = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] base_char;
        logic [7:0] qual_char;
        logic       record_last;
        logic [2:0] error_code;
    } out_word_t;

    // One parse step as handed from the controller to the output pipeline
    typedef struct packed {
        logic      has_result;
        logic      base_from_ram;
        out_word_t word;
    } step_t;

endpackage

### sv/fqp_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one word of a given type.
// Depends on nothing; the word type is set where the channel is declared.
interface fqp_stream_if #(parameter type word_t = logic [7:0]);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/fqp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### sv/fqp_ctrl.sv
`timescale 1ns / 1ps
// Parse state machine: phase, previous byte, read length and quality index.
// Depends on fqp_pkg; drives the write and read ports of the sequence store.
module fqp_ctrl #(
    parameter int MAX_READ_LEN = 1024,
    parameter int AW = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  fqp_pkg::in_word_t in_word,
    output fqp_pkg::step_t   step,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [7:0]       ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    output logic [2:0]       phase
);
    import fqp_pkg::*;

    localparam int LW = $clog2(MAX_READ_LEN + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_READ_LEN);

    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    prev_reg, prev_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] qidx_reg, qidx_next;
    logic [LW-1:0] qidx_inc;
    logic          line_start;
    logic [7:0]    c;

    assign c          = in_word.in_byte;
    assign line_start = (prev_reg == CH_NL);
    assign qidx_inc   = qidx_reg + LW'(1);

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        qidx_next  = qidx_reg;
        step       = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = len_reg[AW-1:0];
        ram_wdata  = c;
        ram_raddr  = qidx_reg[AW-1:0];

        if (accept && phase_reg != PH_ERROR && phase_reg != PH_DONE)
        begin
            if (in_word.end_of_input)
            begin
                step.has_result = 1'b1;
                if (phase_reg == PH_SEEK ||
                    (phase_reg == PH_SKIP_PLUS && len_reg == '0))
                begin
                    phase_next     = PH_DONE;
                    step.word.kind = KIND_END;
                end
                else
                begin
                    phase_next           = PH_ERROR;
                    step.word.kind       = KIND_ERROR;
                    step.word.error_code = ERR_TRUNC;
                end
            end
            else
            begin
                prev_next = c;
                unique case (phase_reg)
                    PH_SEEK:
                    begin
                        if (c != CH_NL)
                        begin
                            step.has_result = 1'b1;
                            if (c == CH_AT && line_start)
                            begin
                                phase_next          = PH_SKIP_HDR;
                                len_next            = '0;
                                qidx_next           = '0;
                                step.word.kind      = KIND_SEP;
                                step.word.base_char = CH_N;
                            end
                            else
                            begin
                                phase_next           = PH_ERROR;
                                step.word.kind       = KIND_ERROR;
                                step.word.error_code = ERR_EXPECT_AT;
                            end
                        end
                    end
                    PH_SKIP_HDR:
                    begin
                        if (c == CH_NL)
                        begin
                            phase_next = PH_SEQ;
                        end
                    end
                    PH_SEQ:
                    begin
                        if (c == CH_NL)
                        begin
                            // skip line breaks inside the sequence
                        end
                        else if (c == CH_PLUS && line_start)
                        begin
                            phase_next = PH_SKIP_PLUS;
                        end
                        else if (len_reg >= MAX_LEN)
                        begin
                            phase_next           = PH_ERROR;
                            step.has_result      = 1'b1;
                            step.word.kind       = KIND_ERROR;
                            step.word.error_code = ERR_TOO_LONG;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            len_next = len_reg + LW'(1);
                        end
                    end
                    PH_SKIP_PLUS:
                    begin
                        if (c == CH_NL)
                        begin
                            phase_next = (len_reg == '0) ? PH_SEEK : PH_QUAL;
                        end
                    end
                    PH_QUAL:
                    begin
                        if (c == CH_NL)
                        begin
                            // skip line breaks inside the quality lines
                        end
                        else if (c == CH_AT && line_start)
                        begin
                            phase_next           = PH_ERROR;
                            step.has_result      = 1'b1;
                            step.word.kind       = KIND_ERROR;
                            step.word.error_code = ERR_SHORT_QUAL;
                        end
                        else
                        begin
                            // the index stays below the length here, so the
                            // entry was written for this record
                            ram_re               = 1'b1;
                            step.has_result      = 1'b1;
                            step.base_from_ram   = 1'b1;
                            step.word.kind       = KIND_PAIR;
                            step.word.qual_char  = c;
                            qidx_next            = qidx_inc;
                            if (qidx_inc >= len_reg)
                            begin
                                step.word.record_last = 1'b1;
                                phase_next            = PH_SEEK;
                                len_next              = '0;
                                qidx_next             = '0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            prev_reg  <= CH_NL;
            len_reg   <= '0;
            qidx_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            qidx_reg  <= qidx_next;
        end
    end

    assign phase = phase_reg;
endmodule

### sv/fastq_seq_qual_pair_parser.sv
`timescale 1ns / 1ps
// Top level of the FASTQ sequence/quality pair parser.
// Depends on fqp_pkg, fqp_stream_if, fqp_ram and fqp_ctrl.
//
//   channel  | dir | word        | fields
//   ---------+-----+-------------+---------------------------------------------
//   text     | in  | in_word_t   | in_byte, end_of_input
//   result   | out | out_word_t  | kind, base_char, qual_char, record_last,
//            |     |             | error_code
//
// One text byte is taken every cycle while text.ready is high. A result
// passes the registered read of the sequence store, then the output
// register. The sequence store RAM needs no clearing pass after reset;
// only entries written for the current record are ever read.
// A stalled result holds in the output register while one more byte enters
// the stage behind it; text.ready drops only when both stages are full.
module fastq_seq_qual_pair_parser #(
    parameter int MAX_READ_LEN = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    fqp_stream_if.sink          text,
    fqp_stream_if.source        result
);
    import fqp_pkg::*;

    localparam int AW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;

    logic            accept;
    step_t           step;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic [2:0]      phase;

    // read stage: waits on the RAM read data
    logic            rd_valid_reg, rd_valid_next;
    step_t           rd_step_reg;
    // output register
    logic            out_valid_reg, out_valid_next;
    out_word_t       out_word_reg;
    logic            rd_move;
    out_word_t       rd_word;

    // Advance the read stage when the output register is empty or drains.
    assign rd_move      = !out_valid_reg || result.ready;
    assign text.ready   = !rd_valid_reg || rd_move;
    assign accept       = text.valid && text.ready;

    fqp_ctrl #(
        .MAX_READ_LEN (MAX_READ_LEN),
        .AW           (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_word   (text.data),
        .step      (step),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .phase     (phase)
    );

    // Writes happen only in the sequence lines and reads only in the quality
    // lines; the plus line lies between, so a read never meets a write still
    // in flight to the same entry.
    fqp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_READ_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Merge the stored base into the pair word as it leaves the read stage.
    // The RAM output holds until the next read, which comes only with the
    // next accepted byte, on the same edge that moves this stage on.
    always_comb
    begin
        rd_word = rd_step_reg.word;
        if (rd_step_reg.base_from_ram)
        begin
            rd_word.base_char = ram_rdata;
        end
    end

    always_comb
    begin
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (rd_valid_reg && rd_move)
        begin
            out_valid_next = 1'b1;
            rd_valid_next  = 1'b0;
        end
        if (accept)
        begin
            // drop steps that make no result
            rd_valid_next = step.has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_step_reg <= step;
        end
        if (rd_valid_reg && rd_move)
        begin
            out_word_reg <= rd_word;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    // The store is never written and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("sequence store written and read in one cycle");

    // A full read stage behind a stalled output stays full.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && out_valid_reg && !result.ready |=> rd_valid_reg)
        else $error("read stage lost a word under stall");

    // Once stopped, the parser makes no further results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase == PH_ERROR || phase == PH_DONE) && accept |-> !step.has_result)
        else $error("result after error or clean end");

    // A pair only ever comes from a RAM read.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && step.word.kind == KIND_PAIR && step.has_result |-> ram_re)
        else $error("pair without store read");
endmodule
